>>> hdl/chv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_pkg
// Types and constants shared by the cartridge header validator modules.
// ----------------------------------------------------------------------------
package chv_pkg;

	localparam int POS_W   = 9;
	localparam int CRC_W   = 16;
	localparam int WORD_W  = 32;
	localparam int N_WORDS = 11;
	localparam int N_BYTES = 3;

	localparam logic [POS_W-1:0]  HDR_MIN  = 9'h160;
	localparam logic [POS_W-1:0]  CRC_END  = 9'h15E;
	localparam logic [POS_W-1:0]  POS_MAX  = 9'h1FF;
	localparam logic [POS_W-1:0]  POS_UNIT = 9'h012;
	localparam logic [POS_W-1:0]  POS_CAP  = 9'h014;
	localparam logic [POS_W-1:0]  POS_VER  = 9'h01E;
	localparam logic [WORD_W-1:0] HDR_MIN_W = 32'h0000_0160;

	// word-aligned offsets, as position bits [8:2]
	localparam logic [6:0] WA_GAME_CODE = 7'h03;
	localparam logic [6:0] WA_BANNER    = 7'h1A;
	localparam logic [6:0] WA_IMG_LEN   = 7'h20;
	localparam logic [6:0] WA_HDR_LEN   = 7'h21;
	// executable block 0x20..0x3F, as position bits [8:5]
	localparam logic [3:0] EXE_BLOCK    = 4'h1;

	localparam logic [3:0] W_MAIN_OFF   = 4'd0;
	localparam logic [3:0] W_MAIN_ENTRY = 4'd1;
	localparam logic [3:0] W_MAIN_LOAD  = 4'd2;
	localparam logic [3:0] W_MAIN_SIZE  = 4'd3;
	localparam logic [3:0] W_SUB_OFF    = 4'd4;
	localparam logic [3:0] W_SUB_ENTRY  = 4'd5;
	localparam logic [3:0] W_SUB_LOAD   = 4'd6;
	localparam logic [3:0] W_SUB_SIZE   = 4'd7;
	localparam logic [3:0] W_BANNER     = 4'd8;
	localparam logic [3:0] W_IMG_LEN    = 4'd9;
	localparam logic [3:0] W_HDR_LEN    = 4'd10;

	localparam logic [1:0] B_UNIT = 2'd0;
	localparam logic [1:0] B_CAP  = 2'd1;
	localparam logic [1:0] B_VER  = 2'd2;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]       CHAR_SPACE = 8'h20;

	typedef enum logic [2:0] {
		STATUS_OK           = 3'd0,
		STATUS_TOO_SMALL    = 3'd1,
		STATUS_BAD_HEADER   = 3'd2,
		STATUS_CRC_MISMATCH = 3'd3,
		STATUS_REGION_OOB   = 3'd4
	} status_t;

	typedef struct packed {
		logic [POS_W-1:0]                pos;
		logic [CRC_W-1:0]                crc;
		logic                            code_ok;
		logic [N_WORDS-1:0][WORD_W-1:0]  words;
		logic [N_BYTES-1:0][7:0]         bytes;
		logic [CRC_W-1:0]                stored_crc;
	} hdr_state_t;

	localparam hdr_state_t HDR_STATE_RESET = '{
		pos:        '0,
		crc:        CRC_INIT,
		code_ok:    1'b1,
		words:      '0,
		bytes:      '0,
		stored_crc: '0
	};

endpackage

>>> hdl/chv_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_crc16
// One-byte update of a reflected CRC-16 (polynomial 0xA001).
// ----------------------------------------------------------------------------
module chv_crc16
	import chv_pkg::*;
(
	input  logic [CRC_W-1:0] crc_in,
	input  logic [7:0]       data,
	output logic [CRC_W-1:0] crc_out
);

	logic [CRC_W-1:0] c;

	always_comb begin
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

>>> hdl/chv_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_capture
// Header stream state: byte count, running CRC, game code flag and the
// captured header words and bytes. Presents the state after the current byte.
// ----------------------------------------------------------------------------
module chv_capture
	import chv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] data,
	input  logic       last,
	output hdr_state_t nx
);

	hdr_state_t       st_q;
	logic [CRC_W-1:0] crc_upd;
	logic [POS_W-1:0] p;

	assign p = st_q.pos;

	chv_crc16 u_crc (
		.crc_in  (st_q.crc),
		.data    (data),
		.crc_out (crc_upd)
	);

	always_comb begin
		nx = st_q;
		if (p < HDR_MIN) begin
			if (p < CRC_END) begin
				nx.crc = crc_upd;
			end
			if (p[8:2] == WA_GAME_CODE && (data == 8'h00 || data == CHAR_SPACE)) begin
				nx.code_ok = 1'b0;
			end
			if (p == POS_UNIT) nx.bytes[B_UNIT] = data;
			if (p == POS_CAP)  nx.bytes[B_CAP]  = data;
			if (p == POS_VER)  nx.bytes[B_VER]  = data;
			if (p[8:5] == EXE_BLOCK) begin
				nx.words[{1'b0, p[4:2]}][8*p[1:0] +: 8] = data;
			end
			if (p[8:2] == WA_BANNER)  nx.words[W_BANNER][8*p[1:0] +: 8]  = data;
			if (p[8:2] == WA_IMG_LEN) nx.words[W_IMG_LEN][8*p[1:0] +: 8] = data;
			if (p[8:2] == WA_HDR_LEN) nx.words[W_HDR_LEN][8*p[1:0] +: 8] = data;
			if (p == CRC_END)          nx.stored_crc[7:0]  = data;
			if (p == CRC_END + 9'd1)   nx.stored_crc[15:8] = data;
		end
		if (p != POS_MAX) begin
			nx.pos = p + 9'd1;
		end
	end

	// start afresh after the closing byte of a header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= HDR_STATE_RESET;
		end else if (byte_en) begin
			st_q <= last ? HDR_STATE_RESET : nx;
		end
	end

endmodule

>>> hdl/chv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_check
// Status decision for a complete header, checks taken in priority order.
// ----------------------------------------------------------------------------
module chv_check
	import chv_pkg::*;
(
	input  hdr_state_t        st,
	input  logic [WORD_W-1:0] image_length,
	output status_t           status
);

	logic [WORD_W:0] main_end;
	logic [WORD_W:0] sub_end;
	logic            main_ok;
	logic            sub_ok;
	logic            hdr_len_bad;

	assign main_end = {1'b0, st.words[W_MAIN_OFF]} + {1'b0, st.words[W_MAIN_SIZE]};
	assign sub_end  = {1'b0, st.words[W_SUB_OFF]} + {1'b0, st.words[W_SUB_SIZE]};

	assign main_ok = (st.words[W_MAIN_SIZE] != '0) && (st.words[W_MAIN_OFF] >= HDR_MIN_W)
		&& (main_end <= {1'b0, image_length});
	assign sub_ok  = (st.words[W_SUB_SIZE] != '0) && (st.words[W_SUB_OFF] >= HDR_MIN_W)
		&& (sub_end <= {1'b0, image_length});

	assign hdr_len_bad = (st.words[W_HDR_LEN] < HDR_MIN_W)
		|| (st.words[W_HDR_LEN] > image_length);

	always_comb begin
		if (st.pos < HDR_MIN || image_length < HDR_MIN_W) begin
			status = STATUS_TOO_SMALL;
		end else if (!st.code_ok || hdr_len_bad) begin
			status = STATUS_BAD_HEADER;
		end else if (st.stored_crc != st.crc) begin
			status = STATUS_CRC_MISMATCH;
		end else if (!main_ok || !sub_ok) begin
			status = STATUS_REGION_OOB;
		end else begin
			status = STATUS_OK;
		end
	end

endmodule

>>> hdl/cartridge_header_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_header_validator
// Streams a cartridge header one byte per transaction and reports its fields
// and a validity status on the byte marked last.
// ----------------------------------------------------------------------------
// Usage:
//   Write image_length through cfg_wr_en / cfg_wr_data while the block is
//   idle. Feed header bytes in file order on the in_* channel (valid/ready),
//   raising last_byte on the final byte. One byte is taken every cycle unless a
//   final byte is held back (see below). Bytes without last_byte produce
//   nothing; the last byte produces one result transaction on the out_*
//   channel: the byte passes through the input register, and from there the
//   CRC update, capture and check logic feed the result register, which raises out_valid.
//   After the last byte the stream state returns to its reset values, so the
//   next header may follow in the very next cycle.
//   When the receiver stalls, the result is held in the output register and
//   non-final bytes keep flowing; a final byte waits in the input register
//   until the output register frees, and in_ready is low only while it waits.
//   Reset clears image_length, the stream state and both valid flags.
// ----------------------------------------------------------------------------
module cartridge_header_validator
	import chv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [7:0]        unit_id,
	output logic [7:0]        capacity_code,
	output logic [7:0]        version_byte,
	output logic [WORD_W-1:0] main_cpu_entry,
	output logic [WORD_W-1:0] main_cpu_load_address,
	output logic [WORD_W-1:0] sub_cpu_entry,
	output logic [WORD_W-1:0] sub_cpu_load_address,
	output logic [WORD_W-1:0] banner_location,
	output logic [WORD_W-1:0] declared_image_len,
	output logic [WORD_W-1:0] declared_header_len,
	output logic [CRC_W-1:0]  computed_crc
);

	logic [WORD_W-1:0] image_length_q;
	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              s1_move;
	hdr_state_t        nx;
	status_t           status_nx;
	status_t           status_q;
	hdr_state_t        res_q;

	assign out_free = !out_valid_q || out_ready;
	assign s1_move  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= '0;
		end else if (cfg_wr_en) begin
			image_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	chv_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (s1_move),
		.data    (data_s1),
		.last    (last_s1),
		.nx      (nx)
	);

	chv_check u_check (
		.st           (nx),
		.image_length (image_length_q),
		.status       (status_nx)
	);

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			status_q <= status_nx;
			res_q    <= nx;
		end
	end

	assign out_valid             = out_valid_q;
	assign status                = status_q;
	assign unit_id               = res_q.bytes[B_UNIT];
	assign capacity_code         = res_q.bytes[B_CAP];
	assign version_byte          = res_q.bytes[B_VER];
	assign main_cpu_entry        = res_q.words[W_MAIN_ENTRY];
	assign main_cpu_load_address = res_q.words[W_MAIN_LOAD];
	assign sub_cpu_entry         = res_q.words[W_SUB_ENTRY];
	assign sub_cpu_load_address  = res_q.words[W_SUB_LOAD];
	assign banner_location       = res_q.words[W_BANNER];
	assign declared_image_len    = res_q.words[W_IMG_LEN];
	assign declared_header_len   = res_q.words[W_HDR_LEN];
	assign computed_crc          = res_q.crc;

endmodule
